[rtl/rhsv_pkg.sv]
// rhsv_pkg: shared widths and the per-cell data bundle for the rgb to hsv converter
// no dependencies; used by rhsv_front, rhsv_cell and rgb_to_hsv_convert_top
package rhsv_pkg;

  localparam int PIX_W     = 8;   // channel width
  localparam int HUE_OUT_W = 16;  // width of the hue port
  localparam int SPAN_W    = 11;  // 6*d fits in 11 bits (6*255 = 1530)
  localparam int NUM_W     = 16;  // d*255 fits in 16 bits

  // data carried from one divider cell to the next (hue quotient travels apart)
  typedef struct packed {
    logic              valid;
    logic              undef;       // grey pixel
    logic [PIX_W-1:0]  vmax;        // brightness, also the saturation divisor
    logic [PIX_W-1:0]  sat_rem;     // saturation partial remainder
    logic [PIX_W-1:0]  sat_num_lo;  // numerator bits still to shift in
    logic [PIX_W-1:0]  sat_q;       // saturation quotient bits so far
    logic [SPAN_W-1:0] hue_rem;     // hue partial remainder
    logic [SPAN_W-1:0] hue_span;    // hue divisor, 6*d
  } cell_data_t;

endpackage

[rtl/rgb_to_hsv_convert_top.sv]
// rgb_to_hsv_convert_top: pipelined rgb to hsv conversion, one pixel per clock
// a start transfer passes the front register, each cell register and the output register before out_valid
// throughput one pixel every cycle; busy is never raised and the receiver cannot stall
// synchronous active-low reset clears the divider chain data and out_valid; the hue quotient
// and output payload registers are not reset
// depends on rhsv_pkg, rhsv_front, rhsv_cell
module rgb_to_hsv_convert_top import rhsv_pkg::*; #(
  parameter int HUE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 start,
  output logic                 busy,
  input  logic [PIX_W-1:0]     in_red,
  input  logic [PIX_W-1:0]     in_green,
  input  logic [PIX_W-1:0]     in_blue,
  // result channel
  output logic                 out_valid,
  output logic [HUE_OUT_W-1:0] out_hue,
  output logic [PIX_W-1:0]     out_saturation,
  output logic [PIX_W-1:0]     out_brightness,
  output logic                 out_hue_undefined
);

  // the pipeline advances every cycle, so a new pixel is always welcome
  assign busy = 1'b0;

  // stage 0: max/min, sector pick and divider operands
  cell_data_t          chain [0:HUE_BITS];
  logic [HUE_BITS-1:0] hue_q [0:HUE_BITS];

  rhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (start & ~busy),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .data_out (chain[0])
  );

  assign hue_q[0] = '0;

  // one cell per hue quotient bit; the first PIX_W cells also retire
  // one saturation quotient bit each
  for (genvar i = 0; i < HUE_BITS; i++) begin : g_cell
    rhsv_cell #(
      .HUE_BITS (HUE_BITS),
      .SAT_STEP (i < PIX_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .data_in   (chain[i]),
      .hue_q_in  (hue_q[i]),
      .data_out  (chain[i+1]),
      .hue_q_out (hue_q[i+1])
    );
  end

  // output register: grey pixels force hue and saturation to zero, which
  // also hides the meaningless quotients from a zero divisor
  logic                 out_valid_r;
  logic [HUE_OUT_W-1:0] out_hue_r;
  logic [PIX_W-1:0]     out_sat_r;
  logic [PIX_W-1:0]     out_bright_r;
  logic                 out_undef_r;
  logic [HUE_OUT_W-1:0] out_hue_nxt;
  logic [PIX_W-1:0]     out_sat_nxt;

  always_comb begin
    out_hue_nxt = chain[HUE_BITS].undef ? '0 : HUE_OUT_W'(hue_q[HUE_BITS]);
    out_sat_nxt = chain[HUE_BITS].undef ? '0 : chain[HUE_BITS].sat_q;
  end

  always_ff @(posedge clk) begin
    out_hue_r    <= out_hue_nxt;
    out_sat_r    <= out_sat_nxt;
    out_bright_r <= chain[HUE_BITS].vmax;
    out_undef_r  <= chain[HUE_BITS].undef;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[HUE_BITS].valid;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hue           = out_hue_r;
  assign out_saturation    = out_sat_r;
  assign out_brightness    = out_bright_r;
  assign out_hue_undefined = out_undef_r;

endmodule

[rtl/rhsv_front.sv]
// rhsv_front: max/min search, sector choice and divider set-up, one register stage
// depends on rhsv_pkg
module rhsv_front import rhsv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  output cell_data_t       data_out
);

  cell_data_t data_r;
  cell_data_t data_nxt;

  logic [PIX_W-1:0]  vmax;
  logic [PIX_W-1:0]  vmin;
  logic [PIX_W-1:0]  d;
  logic [NUM_W-1:0]  sat_num;
  logic [SPAN_W-1:0] span;
  logic signed [SPAN_W+1:0] t;
  logic signed [SPAN_W+1:0] t_wrap;

  always_comb begin
    vmax = (red > green) ? red : green;
    vmax = (vmax > blue) ? vmax : blue;
    vmin = (red < green) ? red : green;
    vmin = (vmin < blue) ? vmin : blue;
    d    = vmax - vmin;

    sat_num = {d, 8'h00} - NUM_W'(d);
    span    = SPAN_W'({d, 2'b00}) + SPAN_W'({d, 1'b0});

    // red wins ties, then green
    if (red == vmax) begin
      t = $signed((SPAN_W+2)'(green)) - $signed((SPAN_W+2)'(blue));
    end else if (green == vmax) begin
      t = $signed((SPAN_W+2)'({d, 1'b0})) + $signed((SPAN_W+2)'(blue))
          - $signed((SPAN_W+2)'(red));
    end else begin
      t = $signed((SPAN_W+2)'({d, 2'b00})) + $signed((SPAN_W+2)'(red))
          - $signed((SPAN_W+2)'(green));
    end
    // negative red-sector hue wraps one full turn
    t_wrap = t[SPAN_W+1] ? t + $signed((SPAN_W+2)'(span)) : t;

    data_nxt.valid      = take;
    data_nxt.undef      = (d == '0);
    data_nxt.vmax       = vmax;
    data_nxt.sat_rem    = sat_num[NUM_W-1:PIX_W];
    data_nxt.sat_num_lo = sat_num[PIX_W-1:0];
    data_nxt.sat_q      = '0;
    data_nxt.hue_rem    = t_wrap[SPAN_W-1:0];
    data_nxt.hue_span   = span;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_out = data_r;

endmodule

[rtl/rhsv_cell.sv]
// rhsv_cell: one restoring-division step for hue, plus one for saturation when enabled
// depends on rhsv_pkg
module rhsv_cell import rhsv_pkg::*; #(
  parameter int  HUE_BITS = 16,
  parameter bit  SAT_STEP = 1'b1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_data_t          data_in,
  input  logic [HUE_BITS-1:0] hue_q_in,
  output cell_data_t          data_out,
  output logic [HUE_BITS-1:0] hue_q_out
);

  cell_data_t          data_r;
  cell_data_t          data_nxt;
  logic [HUE_BITS-1:0] hue_q_r;
  logic [HUE_BITS-1:0] hue_q_nxt;

  logic [SPAN_W:0] hrem2;
  logic            hge;
  logic [PIX_W:0]  srem2;
  logic            sge;

  always_comb begin
    data_nxt = data_in;

    // hue step: shift remainder, subtract span when it fits
    hrem2 = {data_in.hue_rem, 1'b0};
    hge   = hrem2 >= {1'b0, data_in.hue_span};
    data_nxt.hue_rem = hge ? SPAN_W'(hrem2 - {1'b0, data_in.hue_span})
                           : SPAN_W'(hrem2);
    hue_q_nxt = {hue_q_in[HUE_BITS-2:0], hge};

    // saturation step: bring down next numerator bit
    srem2 = {data_in.sat_rem, data_in.sat_num_lo[PIX_W-1]};
    sge   = srem2 >= {1'b0, data_in.vmax};
    if (SAT_STEP) begin
      data_nxt.sat_rem    = sge ? PIX_W'(srem2 - {1'b0, data_in.vmax}) : PIX_W'(srem2);
      data_nxt.sat_num_lo = {data_in.sat_num_lo[PIX_W-2:0], 1'b0};
      data_nxt.sat_q      = {data_in.sat_q[PIX_W-2:0], sge};
    end
  end

  always_ff @(posedge clk) begin
    hue_q_r <= hue_q_nxt;
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_out  = data_r;
  assign hue_q_out = hue_q_r;

endmodule

[tb/tb.sv]
// tb: self-checking bench for rgb_to_hsv_convert_top, directed pixel table then random pixels
// the expected hsv values come from a local integer-exact rewrite of the conversion
// depends on rhsv_pkg and rgb_to_hsv_convert_top
module tb;
  import rhsv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HUE_W       = 16;         // hue resolution, units of 1/2^HUE_W turn
  localparam int NUM_RANDOM  = 1525;       // random pixels after the directed table
  localparam int DRAIN_LIMIT = 400;        // cycles allowed for the pipeline to empty
  localparam int SETTLE      = HUE_W + 6;  // extra cycles after the last result

  // one hsv result as it appears on the out_ ports
  typedef struct packed {
    logic [HUE_OUT_W-1:0] hue;
    logic [PIX_W-1:0]     sat;
    logic [PIX_W-1:0]     value;
    logic                 undef;
  } hsv_t;

  // a row of the directed table; known rows carry the hsv typed in by hand
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             known;
    hsv_t             hsv;
  } pixel_case_t;

  localparam hsv_t HSV_NONE = '0;
  localparam logic [PIX_W-1:0] RAIL_VALUES [4] = '{8'd0, 8'd1, 8'd254, 8'd255};

  localparam int NUM_DIRECTED = 24;
  pixel_case_t directed_px [NUM_DIRECTED] = '{
    // grey pixels: hue undefined, zero saturation
    '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0,     8'd0,   8'd0,   1'b1}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0,     8'd0,   8'd255, 1'b1}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{16'd0,     8'd0,   8'd128, 1'b1}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{16'd0,     8'd0,   8'd1,   1'b1}},
    // primaries and secondaries at full scale
    '{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0,     8'd255, 8'd255, 1'b0}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{16'd21845, 8'd255, 8'd255, 1'b0}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{16'd43690, 8'd255, 8'd255, 1'b0}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{16'd10922, 8'd255, 8'd255, 1'b0}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{16'd32768, 8'd255, 8'd255, 1'b0}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{16'd54613, 8'd255, 8'd255, 1'b0}},
    // smallest non-grey pixel
    '{8'd1,   8'd0,   8'd0,   1'b1, '{16'd0,     8'd255, 8'd1,   1'b0}},
    // pixels next to sector edges; the first, red sector just below zero, wraps to the top
    '{8'd255, 8'd0,   8'd1,   1'b0, HSV_NONE},
    '{8'd255, 8'd1,   8'd0,   1'b0, HSV_NONE},
    '{8'd0,   8'd255, 8'd1,   1'b0, HSV_NONE},
    '{8'd1,   8'd255, 8'd0,   1'b0, HSV_NONE},
    '{8'd0,   8'd1,   8'd255, 1'b0, HSV_NONE},
    // ties for the largest channel (red beats green and blue, green beats blue), then mixed pixels
    '{8'd255, 8'd255, 8'd254, 1'b0, HSV_NONE},
    '{8'd254, 8'd255, 8'd255, 1'b0, HSV_NONE},
    '{8'd255, 8'd254, 8'd255, 1'b0, HSV_NONE},
    '{8'd0,   8'd0,   8'd1,   1'b0, HSV_NONE},
    '{8'd2,   8'd1,   8'd0,   1'b0, HSV_NONE},
    '{8'd170, 8'd85,  8'd255, 1'b0, HSV_NONE},
    '{8'd255, 8'd254, 8'd253, 1'b0, HSV_NONE},
    '{8'd128, 8'd127, 8'd0,   1'b0, HSV_NONE}
  };

  logic             clk      = 1'b0;
  logic             rst_n    = 1'b0;
  logic             start    = 1'b0;
  logic [PIX_W-1:0] in_red   = '0;
  logic [PIX_W-1:0] in_green = '0;
  logic [PIX_W-1:0] in_blue  = '0;

  logic                 busy;
  logic                 out_valid;
  logic [HUE_OUT_W-1:0] out_hue;
  logic [PIX_W-1:0]     out_saturation;
  logic [PIX_W-1:0]     out_brightness;
  logic                 out_hue_undefined;

  hsv_t pending_hsv [$];  // expected hsv of every accepted pixel, oldest first
  int   error_count = 0;

  rgb_to_hsv_convert_top #(
    .HUE_BITS(HUE_W)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_hue          (out_hue),
    .out_saturation   (out_saturation),
    .out_brightness   (out_brightness),
    .out_hue_undefined(out_hue_undefined)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact integer hsv of one pixel; the hue division is floored, so no rounding slack
  function automatic hsv_t hsv_of(input logic [PIX_W-1:0] r, g, b);
    int unsigned vmax;
    int unsigned vmin;
    int unsigned d;
    longint      t;
    longint      span;
    longint      q;
    hsv_t        res;
    vmax = (r > g) ? r : g;
    vmax = (vmax > b) ? vmax : b;
    vmin = (r < g) ? r : g;
    vmin = (vmin < b) ? vmin : b;
    d = vmax - vmin;
    res = '0;
    res.value = vmax[PIX_W-1:0];
    res.undef = 1'b1;
    if (vmax != 0) begin
      res.sat = PIX_W'((d * 255) / vmax);
    end
    if (d != 0) begin
      span = 6 * longint'(d);
      // the largest channel picks the sector; red wins ties, then green
      if (r == vmax) begin
        t = longint'(g) - longint'(b);
      end else if (g == vmax) begin
        t = 2 * longint'(d) + longint'(b) - longint'(r);
      end else begin
        t = 4 * longint'(d) + longint'(r) - longint'(g);
      end
      // negative red-sector hue wraps one full turn
      if (t < 0) begin
        t = t + span;
      end
      q = (t <<< HUE_W) / span;
      res.hue   = q[HUE_OUT_W-1:0];
      res.undef = 1'b0;
    end
    return res;
  endfunction

  // one field mismatch: count it and report it
  task automatic report_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // drive one pixel and hold it until the start transfer happens; the caller
  // is at a rising edge on entry and on return. a non-zero gap drops start and
  // puts junk on the channel ports, which the block must ignore
  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, input hsv_t want, input int gap);
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    // transfer taken at this edge, so the result is owed from now on
    pending_hsv.push_back(want);
    if (gap > 0) begin
      start    <= 1'b0;
      in_red   <= PIX_W'($urandom);
      in_green <= PIX_W'($urandom);
      in_blue  <= PIX_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: every out_valid strobe is a transfer, matched against the oldest
  // pixel still owed; values sampled before the edge updates them
  always @(posedge clk) begin : result_check
    hsv_t want;
    if (rst_n && out_valid) begin
      if (pending_hsv.size() == 0) begin
        error_count++;
        $display({"%0t ns: result with none expected, expected nothing, ",
                  "actual hue %0d sat %0d val %0d undef %0b"},
                 $time, out_hue, out_saturation, out_brightness, out_hue_undefined);
      end else begin
        want = pending_hsv.pop_front();
        report_field("hue",           want.hue,   out_hue);
        report_field("saturation",    want.sat,   out_saturation);
        report_field("brightness",    want.value, out_brightness);
        report_field("hue_undefined", want.undef, out_hue_undefined);
      end
    end
  end

  // stimulus: reset, directed table, random pixels, then drain and verdict
  initial begin : stimulus
    hsv_t             want;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] other;
    int               gap;
    int               idle_mode;
    int               waited;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; rows without a typed-in hsv are checked against hsv_of
    foreach (directed_px[i]) begin
      want = directed_px[i].known ? directed_px[i].hsv
                                  : hsv_of(directed_px[i].red, directed_px[i].green,
                                           directed_px[i].blue);
      send_pixel(directed_px[i].red, directed_px[i].green, directed_px[i].blue, want,
                 $urandom_range(0, 17));
    end

    idle_mode = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // idle pattern is picked anew every 64 pixels: back to back, uniform gaps, or bursty
      if (n % 64 == 0) begin
        idle_mode = $urandom_range(0, 2);
      end
      case ($urandom_range(0, 9))
        0: begin
          // grey
          r = PIX_W'($urandom);
          g = r;
          b = r;
        end
        1, 2: begin
          // two channels tie for the largest
          top   = PIX_W'($urandom_range(1, 255));
          other = PIX_W'($urandom_range(0, top - 1));
          case ($urandom_range(0, 2))
            0: begin r = top;   g = top;   b = other; end
            1: begin r = top;   g = other; b = top;   end
            default: begin r = other; g = top; b = top; end
          endcase
        end
        3: begin
          // dark pixels, small differences
          r = PIX_W'($urandom_range(0, 3));
          g = PIX_W'($urandom_range(0, 3));
          b = PIX_W'($urandom_range(0, 3));
        end
        4: begin
          // channels at or next to the rails
          r = RAIL_VALUES[$urandom_range(0, 3)];
          g = RAIL_VALUES[$urandom_range(0, 3)];
          b = RAIL_VALUES[$urandom_range(0, 3)];
        end
        default: begin
          r = PIX_W'($urandom);
          g = PIX_W'($urandom);
          b = PIX_W'($urandom);
        end
      endcase
      case (idle_mode)
        0: gap = 0;
        1: gap = $urandom_range(0, 17);
        default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
      endcase
      send_pixel(r, g, b, hsv_of(r, g, b), gap);
    end
    start <= 1'b0;

    // let the pipeline empty, then watch a little longer for stray strobes
    waited = 0;
    while (pending_hsv.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_hsv.size() != 0) begin
      error_count += pending_hsv.size();
      $display("%0t ns: %0d results never arrived, expected 0 outstanding, actual %0d",
               $time, pending_hsv.size(), pending_hsv.size());
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
rtl/rhsv_pkg.sv
rtl/rhsv_front.sv
rtl/rhsv_cell.sv
rtl/rgb_to_hsv_convert_top.sv
tb/tb.sv
